// ===== src/bsd_pkg.sv =====
// ----------------------------------------------------------------------------
// bsd_pkg
// Shared types, constants and helpers for the button scan debouncer.
// ----------------------------------------------------------------------------
package bsd_pkg;

  // Button count and derived widths
  localparam int NUM_BUTTONS = 4;
  localparam int PIN_COUNT   = 4;
  localparam int PIN_IDX_W   = $clog2(PIN_COUNT);
  localparam int IDX_W       = $clog2(NUM_BUTTONS + 1);
  localparam int CODE_W      = 3;
  localparam int TIME_W      = 32;

  localparam logic [TIME_W-1:0] SETTLE_DELAY_RST = 32'd6554;

  // Request kinds
  localparam logic REQ_TICK = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Reported phase numbers
  localparam logic [2:0] PHN_SETTLE   = 3'd0;
  localparam logic [2:0] PHN_SCAN     = 3'd1;
  localparam logic [2:0] PHN_DEBOUNCE = 3'd2;
  localparam logic [2:0] PHN_RELEASE  = 3'd3;
  localparam logic [2:0] PHN_HOLD     = 3'd4;

  localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;

  typedef enum logic [4:0] {
    PH_SETTLE   = 5'b00001,
    PH_SCAN     = 5'b00010,
    PH_DEBOUNCE = 5'b00100,
    PH_RELEASE  = 5'b01000,
    PH_HOLD     = 5'b10000
  } phase_t;

  typedef struct packed {
    logic              req_type;
    logic [TIME_W-1:0] timer_now;
    logic [3:0]        pins_level;
  } bsd_in_t;

  typedef struct packed {
    logic [CODE_W-1:0] read_code;
    logic              beep;
    logic [2:0]        phase_now;
  } bsd_out_t;

  typedef struct packed {
    phase_t            phase;
    logic [IDX_W-1:0]  scan_index;
    logic [CODE_W-1:0] held_code;
    logic [TIME_W-1:0] mark_time;
  } bsd_state_t;

  // One-hot phase to reported number
  function automatic logic [2:0] phase_num(phase_t ph);
    logic [2:0] n;
    case (ph)
      PH_SETTLE:   n = PHN_SETTLE;
      PH_SCAN:     n = PHN_SCAN;
      PH_DEBOUNCE: n = PHN_DEBOUNCE;
      PH_RELEASE:  n = PHN_RELEASE;
      PH_HOLD:     n = PHN_HOLD;
      default:     n = PHN_SETTLE;
    endcase
    return n;
  endfunction

endpackage

// ===== src/button_scan_debouncer_core.sv =====
// ----------------------------------------------------------------------------
// button_scan_debouncer_core
// Round-robin button scanner with debounce, release wait and hold.
// ----------------------------------------------------------------------------
// Timing: the input register loads on the transfer edge, the result register
//   on the edge where that item advances; state is updated on the same edge as
//   the result.
// Throughput: one item per cycle while results are taken; a stalled result holds
//   the item in the input register and drops in_ready.
// Reset (rst_n low, synchronous): settle phase, index 0, no held code, mark 0,
//   delay 6554, both pipeline registers empty.
module button_scan_debouncer_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  bsd_pkg::bsd_in_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output bsd_pkg::bsd_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [bsd_pkg::TIME_W-1:0] cfg_wdata
);
  import bsd_pkg::*;

  logic [TIME_W-1:0] delay_r;
  bsd_in_t           item_r;
  logic              item_vld_r;
  bsd_state_t        st_r;
  bsd_state_t        st_nxt;
  bsd_out_t          res_nxt;
  bsd_out_t          res_r;
  logic              res_vld_r;
  logic              advance;

  // Stage 1 moves on when the result register is free or being drained
  assign advance  = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  // Delay register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r <= SETTLE_DELAY_RST;
    end else if (cfg_we) begin
      delay_r <= cfg_wdata;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  bsd_step u_step (
    .st_i   (st_r),
    .item_i (item_r),
    .delay_i(delay_r),
    .st_o   (st_nxt),
    .res_o  (res_nxt)
  );

  // Scanner state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= PH_SETTLE;
      st_r.scan_index <= '0;
      st_r.held_code  <= CODE_NONE;
      st_r.mark_time  <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  // Checks
  a_beep_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.beep |-> out_data.phase_now == PHN_DEBOUNCE)
    else $error("beep without entering debounce");

  a_read_phase: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.read_code != CODE_NONE) |-> out_data.phase_now == PHN_SCAN)
    else $error("held code returned without restarting scan");

  a_beep_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.beep && (out_data.read_code != CODE_NONE)))
    else $error("beep together with a read code");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.scan_index <= IDX_W'(NUM_BUTTONS))
    else $error("scan index past wrap point");

  a_advance_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid)
    else $error("stage transfer lost its result");

endmodule

// ===== src/bsd_step.sv =====
// ----------------------------------------------------------------------------
// bsd_step
// Next-state and result logic for one tick or read transfer.
// ----------------------------------------------------------------------------
module bsd_step (
  input  bsd_pkg::bsd_state_t        st_i,
  input  bsd_pkg::bsd_in_t           item_i,
  input  logic [bsd_pkg::TIME_W-1:0] delay_i,
  output bsd_pkg::bsd_state_t        st_o,
  output bsd_pkg::bsd_out_t          res_o
);
  import bsd_pkg::*;

  logic [TIME_W-1:0]        elapsed;
  logic                     expired;
  logic [PIN_IDX_W+IDX_W-1:0] idx_ext;
  logic                     pin_hi;
  logic [IDX_W:0]           idx_inc;
  logic [CODE_W-1:0]        code;
  logic                     beep;

  // Absolute timer difference against the mark, strictly past the delay
  always_comb begin
    if (item_i.timer_now >= st_i.mark_time) begin
      elapsed = item_i.timer_now - st_i.mark_time;
    end else begin
      elapsed = st_i.mark_time - item_i.timer_now;
    end
    expired = (elapsed > delay_i);
  end

  // Pin of the current button; indexes past the pins read as released
  always_comb begin
    idx_ext = {{PIN_IDX_W{1'b0}}, st_i.scan_index};
    if (idx_ext >= (PIN_IDX_W + IDX_W)'(PIN_COUNT)) begin
      pin_hi = 1'b1;
    end else begin
      pin_hi = item_i.pins_level[idx_ext[PIN_IDX_W-1:0]];
    end
    idx_inc = {1'b0, st_i.scan_index} + 1'b1;
  end

  // Phase update
  always_comb begin
    st_o = st_i;
    code = CODE_NONE;
    beep = 1'b0;
    if (item_i.req_type == REQ_READ) begin
      if (st_i.phase == PH_HOLD) begin
        code            = st_i.held_code;
        st_o.held_code  = CODE_NONE;
        st_o.scan_index = '0;
        st_o.phase      = PH_SCAN;
      end
    end else begin
      case (st_i.phase)
        PH_SETTLE: begin
          if (expired) st_o.phase = PH_SCAN;
        end
        PH_SCAN: begin
          if (st_i.scan_index < IDX_W'(NUM_BUTTONS)) begin
            if (!pin_hi) begin
              st_o.held_code = CODE_W'(idx_inc);
              st_o.mark_time = item_i.timer_now;
              st_o.phase     = PH_DEBOUNCE;
              beep           = 1'b1;
            end else begin
              st_o.scan_index = idx_inc[IDX_W-1:0];
            end
          end else begin
            // wrap costs a tick of its own
            st_o.scan_index = '0;
          end
        end
        PH_DEBOUNCE: begin
          if (expired) st_o.phase = PH_RELEASE;
        end
        PH_RELEASE: begin
          if (pin_hi) begin
            st_o.mark_time = item_i.timer_now;
            st_o.phase     = PH_HOLD;
          end
        end
        PH_HOLD: begin
          if (expired) begin
            st_o.held_code  = CODE_NONE;
            st_o.scan_index = '0;
            st_o.phase      = PH_SCAN;
          end
        end
        default: begin
          st_o = st_i;
        end
      endcase
    end
  end

  assign res_o.read_code = code;
  assign res_o.beep      = beep;
  assign res_o.phase_now = phase_num(st_o.phase);

endmodule

// ===== dv/bsd_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsd_result_checker
// Watches the input, result and configuration ports of the button scan
// debouncer, keeps its own model of phase, scan index, held code and mark,
// and compares every result transfer with the oldest predicted result.
// ----------------------------------------------------------------------------
module bsd_result_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_ready,
  input  bsd_pkg::bsd_in_t           in_data,
  input  logic                       out_valid,
  input  logic                       out_ready,
  input  bsd_pkg::bsd_out_t          out_data,
  input  logic                       cfg_we,
  input  logic [bsd_pkg::TIME_W-1:0] cfg_wdata,
  output int                         err_count,
  output int                         outstanding
);
  import bsd_pkg::*;

  // Model state
  logic [TIME_W-1:0] m_delay;
  logic [TIME_W-1:0] m_mark;
  logic [2:0]        m_phase;
  logic [IDX_W-1:0]  m_index;
  logic [CODE_W-1:0] m_held;

  bsd_out_t predicted_q[$];
  int       n_err = 0;

  // Absolute distance between two timer samples
  function automatic logic [TIME_W-1:0] time_gap(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  // Indexes past the last pin read as released
  function automatic logic pin_released(input logic [3:0] pins,
                                        input logic [IDX_W-1:0] idx);
    if (idx >= PIN_COUNT) return 1'b1;
    return pins[idx[PIN_IDX_W-1:0]];
  endfunction

  function automatic void restart_scan();
    m_held  = CODE_NONE;
    m_index = '0;
    m_phase = PHN_SCAN;
  endfunction

  // Advance the model by one item and return the result it gives
  function automatic bsd_out_t advance_buttons(input bsd_in_t item);
    bsd_out_t r;
    r = '0;
    if (item.req_type == REQ_READ) begin
      // a read only answers in hold, and never beeps
      if (m_phase == PHN_HOLD) begin
        r.read_code = m_held;
        restart_scan();
      end
    end else begin
      case (m_phase)
        PHN_SETTLE: begin
          if (time_gap(item.timer_now, m_mark) > m_delay) m_phase = PHN_SCAN;
        end
        PHN_SCAN: begin
          if (m_index < NUM_BUTTONS) begin
            if (!pin_released(item.pins_level, m_index)) begin
              m_held  = m_index + 1'b1;
              m_mark  = item.timer_now;
              r.beep  = 1'b1;
              m_phase = PHN_DEBOUNCE;
            end else begin
              m_index = m_index + 1'b1;
            end
          end else begin
            // wrap tick: index back to the first button only
            m_index = '0;
          end
        end
        PHN_DEBOUNCE: begin
          if (time_gap(item.timer_now, m_mark) > m_delay) m_phase = PHN_RELEASE;
        end
        PHN_RELEASE: begin
          if (pin_released(item.pins_level, m_index)) begin
            m_mark  = item.timer_now;
            m_phase = PHN_HOLD;
          end
        end
        PHN_HOLD: begin
          if (time_gap(item.timer_now, m_mark) > m_delay) restart_scan();
        end
        default: ;
      endcase
    end
    r.phase_now = m_phase;
    return r;
  endfunction

  // Result check first, then prediction for the input transfer on this edge
  always @(posedge clk) begin
    bsd_out_t want;
    if (!rst_n) begin
      m_delay = SETTLE_DELAY_RST;
      m_mark  = '0;
      m_phase = PHN_SETTLE;
      m_index = '0;
      m_held  = CODE_NONE;
      predicted_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_q.size() == 0) begin
          n_err++;
          if (n_err <= 10)
            $display("%0t: unexpected result code %0d beep %0d phase %0d", $realtime,
                     out_data.read_code, out_data.beep, out_data.phase_now);
        end else begin
          want = predicted_q.pop_front();
          if (want.read_code !== out_data.read_code || want.beep !== out_data.beep ||
              want.phase_now !== out_data.phase_now) begin
            n_err++;
            if (n_err <= 10)
              $display("%0t: mismatch exp code %0d beep %0d phase %0d, got %0d %0d %0d",
                       $realtime, want.read_code, want.beep, want.phase_now,
                       out_data.read_code, out_data.beep, out_data.phase_now);
          end
        end
      end
      if (in_valid && in_ready) predicted_q.push_back(advance_buttons(in_data));
      if (cfg_we) m_delay = cfg_wdata;
    end
    err_count   <= n_err;
    outstanding <= predicted_q.size();
  end

endmodule

// ===== dv/tb_button_scan_debouncer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_button_scan_debouncer_core
// Drives directed and random tick and read items into the button scan
// debouncer under several settle delays, with random gaps and result stalls;
// the result checker predicts and compares, this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_scan_debouncer_core;
  import bsd_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  bsd_in_t           in_data;
  logic              out_valid;
  logic              out_ready;
  bsd_out_t          out_data;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;
  int                err_count;
  int                outstanding;

  logic              calm;      // no gaps and no stalls while set
  logic [TIME_W-1:0] tb_delay;
  logic [TIME_W-1:0] timer_q;
  logic [TIME_W-1:0] delay_plan [8];

  button_scan_debouncer_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  bsd_result_checker result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .err_count   (err_count),
    .outstanding (outstanding)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  initial begin
    #3000000;
    $display("TEST FAILED");
    $finish;
  end

  // Result side back-pressure
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= 8);
  end

  function automatic bsd_in_t make_item(input logic req, input logic [TIME_W-1:0] t,
                                        input logic [3:0] pins);
    bsd_in_t it;
    it.req_type   = req;
    it.timer_now  = t;
    it.pins_level = pins;
    return it;
  endfunction

  // One input transfer, with random gaps ahead of it
  task automatic push_item(input bsd_in_t item);
    while (!calm && $urandom_range(0, 99) < 8) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait until every predicted result has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_delay(input logic [TIME_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tb_delay  = v;
  endtask

  // Random items: timer steps clustered round the delay, mostly idle pins
  task automatic run_random(input int n);
    int                r;
    logic [TIME_W-1:0] step;
    logic [3:0]        pins;
    logic              req;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40)      step = $urandom_range(0, 3);
      else if (r < 58) step = tb_delay >> 1;
      else if (r < 70) step = tb_delay;
      else if (r < 85) step = tb_delay + 1'b1;
      else if (r < 93) step = tb_delay + $urandom_range(2, 60);
      else             step = $urandom;
      if ($urandom_range(0, 4) == 0) timer_q = timer_q - step;
      else                           timer_q = timer_q + step;

      r    = $urandom_range(0, 99);
      pins = 4'hF;
      if (r >= 55 && r < 85) pins[$urandom_range(0, 3)] = 1'b0;
      else if (r >= 85)      pins = 4'($urandom_range(0, 15));

      req = ($urandom_range(0, 99) < 15) ? REQ_READ : REQ_TICK;
      push_item(make_item(req, timer_q, pins));
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    calm      = 1'b0;
    tb_delay  = SETTLE_DELAY_RST;
    timer_q   = '0;
    delay_plan = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd3, 32'd40, 32'h8000_0000,
                   SETTLE_DELAY_RST, 32'd0};
    delay_plan[7] = $urandom_range(0, 300);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Settle from timer 0 under the reset delay; read while settling
    push_item(make_item(REQ_READ, 32'd0,    4'hF));
    push_item(make_item(REQ_TICK, 32'd6554, 4'hF));   // equal, not exceeded
    push_item(make_item(REQ_TICK, 32'd6555, 4'hF));
    // Full round with nothing pressed, then the wrap tick with all pressed
    push_item(make_item(REQ_TICK, 32'd6556, 4'hF));
    push_item(make_item(REQ_TICK, 32'd6557, 4'hF));
    push_item(make_item(REQ_TICK, 32'd6558, 4'hF));
    push_item(make_item(REQ_TICK, 32'd6559, 4'hF));
    push_item(make_item(REQ_TICK, 32'd6560, 4'h0));
    // OK press, read during debounce, debounce edge, release, hold, read
    push_item(make_item(REQ_TICK, 32'd100,  4'b1110));
    push_item(make_item(REQ_READ, 32'd100,  4'b1110));
    push_item(make_item(REQ_TICK, 32'd6654, 4'b1110));
    push_item(make_item(REQ_TICK, 32'hFFFF_FFFF, 4'b1110));
    push_item(make_item(REQ_TICK, 32'd4000, 4'b1110));
    push_item(make_item(REQ_TICK, 32'd5000, 4'hF));
    push_item(make_item(REQ_TICK, 32'd11554, 4'hF));
    push_item(make_item(REQ_READ, 32'd11554, 4'hF));
    // ESC press with the timer running backwards, then hold expiry
    push_item(make_item(REQ_TICK, 32'd20000, 4'b1101));
    push_item(make_item(REQ_TICK, 32'd20000, 4'b1101));
    push_item(make_item(REQ_TICK, 32'd13445, 4'b1101));
    push_item(make_item(REQ_TICK, 32'd13445, 4'hF));
    push_item(make_item(REQ_TICK, 32'd20000, 4'hF));
    push_item(make_item(REQ_READ, 32'd20000, 4'hF));
    // Walk to the DOWN button
    push_item(make_item(REQ_TICK, 32'd0, 4'b0111));
    push_item(make_item(REQ_TICK, 32'd0, 4'b0111));
    push_item(make_item(REQ_TICK, 32'd0, 4'b0111));
    push_item(make_item(REQ_TICK, 32'd0, 4'b0111));

    run_random(200);

    foreach (delay_plan[i]) begin
      write_delay(delay_plan[i]);
      calm = (i == 3);
      run_random((delay_plan[i] == 32'hFFFF_FFFF) ? 60 : 180);
    end
    calm = 1'b0;

    drain();
    if (err_count == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
